// File: design/hsm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsm_pkg;

	localparam int TICK_W     = 64;
	localparam int STAT_W     = 32;
	localparam int FREQ_W     = 32;
	localparam int WORKER_W   = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Milliseconds per second, applied as a bit-serial constant multiplier.
	localparam int MUL_W = 10;
	localparam logic [MUL_W-1:0] MS_PER_S = 10'd1000;

	// Width of diff * 1000, which is both the serial pass length and the dividend width.
	localparam int DVD_W = TICK_W + MUL_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	localparam logic [FREQ_W-1:0] FREQ_DEFAULT   = 32'd54000000;
	localparam logic [TICK_W-1:0] THRESH_DEFAULT = 64'd486000000;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FREQ      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORKER    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PET       = 3'd4;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_ONSET   = 2'd1;
	localparam logic [1:0] EV_MID     = 2'd2;
	localparam logic [1:0] EV_RECOVER = 2'd3;

	typedef struct packed {
		logic [TICK_W-1:0]   now_tick;
		logic [TICK_W-1:0]   heartbeat_tick;
		logic [WORKER_W-1:0] worker_count;
	} sample_t;

	typedef struct packed {
		logic [1:0]          event_kind;
		logic [STAT_W-1:0]   stall_total;
		logic [STAT_W-1:0]   duration_ms;
		logic [STAT_W-1:0]   worst_duration_ms;
		logic [WORKER_W-1:0] worker_advance;
		logic                worker_valid;
		logic                led_on;
		logic                pet_strobe;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

`default_nettype wire

// File: design/hsm_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none

module hsm_serial_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [hsm_pkg::DVD_W-1:0]     dividend,
	input  wire logic [hsm_pkg::FREQ_W-1:0]    divisor,
	output hsm_pkg::div_status_t               status,
	output logic [hsm_pkg::STAT_W-1:0]         quotient
);

	// Restoring division, one quotient bit per cycle, MSB first.
	// Quotient bits that fall off the top of the 32-bit window set the saturation flag.
	logic [hsm_pkg::DVD_W-1:0]  dvd_q;
	logic [hsm_pkg::FREQ_W-1:0] dsr_q;
	logic [hsm_pkg::FREQ_W-1:0] rem_q;
	logic [hsm_pkg::STAT_W-1:0] quo_q;
	logic                       sat_q;
	logic [hsm_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [hsm_pkg::FREQ_W:0]   trial;
	logic [hsm_pkg::FREQ_W:0]   diff;
	logic                       fits;

	assign trial = {rem_q, dvd_q[hsm_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == hsm_pkg::CNT_W'(hsm_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[hsm_pkg::DVD_W-2:0], 1'b0};
			rem_q <= fits ? diff[hsm_pkg::FREQ_W-1:0] : trial[hsm_pkg::FREQ_W-1:0];
			quo_q <= {quo_q[hsm_pkg::STAT_W-2:0], fits};
			sat_q <= sat_q | quo_q[hsm_pkg::STAT_W-1];
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = sat_q ? '1 : quo_q;

endmodule

`default_nettype wire

// File: design/heartbeat_stall_monitor.sv
`timescale 1ns / 1ps
`default_nettype none

// Heartbeat stall monitor.
//
// The sample channel (sample_valid, sample_stall, sample) carries one word per
// heartbeat check: the watcher's tick, the core's last heartbeat stamp and the
// worker progress count. Every accepted word yields exactly one word on the
// result channel (result_valid, result_stall, result) with the event kind,
// the stall statistics, an optional worker-advance report and the lamp level.
// Configuration is written through cfg_we / cfg_index / cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
// All 64-bit arithmetic runs bit-serially, LSB first, in one pass that also
// forms diff * 1000 for the millisecond conversion. After the pass, the
// finish state loads the result into the output register, and sample_stall
// holds off the next sample until the block is back in idle. A recovery adds
// the restoring divider, one quotient bit per cycle, between the pass and the
// finish state. The next sample is taken once the result has entered the
// output register, so a result waiting on result_stall does not hold up the
// following sample; only a second finished result waits. Reset restores the
// configuration defaults (enabled, 9 s threshold at 54 MHz), clears the stall
// flag and counters and empties the output.

module heartbeat_stall_monitor (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output logic                                   sample_stall,
	input  wire hsm_pkg::sample_t                  sample,
	output logic                                   result_valid,
	input  wire logic                              result_stall,
	output hsm_pkg::result_t                       result,
	input  wire logic                              cfg_we,
	input  wire logic [hsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [hsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PASS = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	localparam int TW = hsm_pkg::TICK_W;
	localparam int SW = hsm_pkg::STAT_W;
	localparam int WW = hsm_pkg::WORKER_W;

	// Configuration registers.
	logic                        enable_q;
	logic [TW-1:0]               thresh_q;
	logic [hsm_pkg::FREQ_W-1:0]  freq_q;
	logic                        wrk_armed_q;
	logic                        pet_armed_q;

	// Monitor state.
	logic                        stalled_q;
	logic [TW-1:0]               onset_hb_q;
	logic [WW-1:0]               worker_base_q;
	logic [TW-1:0]               next_rep_q;
	logic [SW-1:0]               stall_cnt_q;
	logic [SW-1:0]               worst_q;

	// Sequencer.
	logic [1:0]                  state_q;
	logic [hsm_pkg::CNT_W-1:0]   cnt_q;

	// Serial pass operands. Sample and state words rotate so they are intact afterwards.
	logic [TW-1:0]               now_sr_q;
	logic [TW-1:0]               hb_sr_q;
	logic [WW-1:0]               wk_sr_q;
	logic [TW-1:0]               thr_sr_q;
	logic [TW-1:0]               f2_sr_q;
	logic [hsm_pkg::FREQ_W-1:0]  freq_eff_q;

	// Serial pass results.
	logic [TW-1:0]               nrt_new_q;
	logic [WW-1:0]               adv_q;
	logic [hsm_pkg::DVD_W-1:0]   prod_q;
	logic                        bw_age_q;
	logic                        bw_dur_q;
	logic                        bw_adv_q;
	logic                        cy_rep_q;
	logic                        now_gt_hb_q;
	logic                        age_gt_thr_q;
	logic                        rep_gt_now_q;
	logic [hsm_pkg::MUL_W-2:0]   hist_q;
	logic [2:0]                  mcy_q;

	// Pending result fields.
	logic [1:0]                  res_kind_q;
	logic [SW-1:0]               res_dur_q;
	logic [WW-1:0]               res_adv_q;
	logic                        res_wv_q;
	logic                        res_pet_q;

	logic                        div_go_q;
	hsm_pkg::div_status_t        div_status;
	logic [SW-1:0]               div_quo;

	hsm_pkg::result_t            result_q;
	logic                        result_valid_q;

	logic                        take;
	logic                        pass_act;
	logic                        pass_last;
	logic                        b_now, b_hb, b_thr, b_rep, b_wk, b_wb, b_oh, b_f2;
	logic                        b_age, b_diff;
	logic [3:0]                  msum;
	logic                        stale;
	logic                        fin_go;

	assign take      = sample_valid && !sample_stall;
	assign pass_act  = cnt_q < hsm_pkg::CNT_W'(TW);
	assign pass_last = cnt_q == hsm_pkg::CNT_W'(hsm_pkg::DVD_W - 1);
	assign fin_go    = (state_q == ST_FIN) && (!result_valid_q || !result_stall);

	assign b_now = now_sr_q[0];
	assign b_hb  = hb_sr_q[0];
	assign b_thr = thr_sr_q[0];
	assign b_rep = next_rep_q[0];
	assign b_wk  = wk_sr_q[0];
	assign b_wb  = worker_base_q[0];
	assign b_oh  = onset_hb_q[0];
	assign b_f2  = f2_sr_q[0];

	assign b_age  = b_now ^ b_hb ^ bw_age_q;
	// Tick difference since the onset heartbeat, zero-padded past the tick width.
	assign b_diff = pass_act & (b_now ^ b_oh ^ bw_dur_q);

	// Constant multiply by 1000: sum the delayed difference bits at the set bit positions.
	always_comb begin
		msum = {1'b0, mcy_q} + 4'(hsm_pkg::MS_PER_S[0] & b_diff);
		for (int j = 1; j < hsm_pkg::MUL_W; j++) begin
			msum = msum + 4'(hsm_pkg::MS_PER_S[j] & hist_q[j-1]);
		end
	end

	assign stale = now_gt_hb_q && age_gt_thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b1;
			thresh_q    <= hsm_pkg::THRESH_DEFAULT;
			freq_q      <= hsm_pkg::FREQ_DEFAULT;
			wrk_armed_q <= 1'b0;
			pet_armed_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				hsm_pkg::CFG_ENABLE:    enable_q    <= cfg_data[0];
				hsm_pkg::CFG_THRESHOLD: thresh_q    <= cfg_data[TW-1:0];
				hsm_pkg::CFG_FREQ:      freq_q      <= cfg_data[hsm_pkg::FREQ_W-1:0];
				hsm_pkg::CFG_WORKER:    wrk_armed_q <= cfg_data[0];
				hsm_pkg::CFG_PET:       pet_armed_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer and monitor state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			div_go_q       <= 1'b0;
			stalled_q      <= 1'b0;
			onset_hb_q     <= '0;
			worker_base_q  <= '0;
			next_rep_q     <= '0;
			stall_cnt_q    <= '0;
			worst_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_PASS;
						cnt_q   <= '0;
					end
				end
				ST_PASS: begin
					cnt_q <= cnt_q + 1'b1;
					if (pass_act) begin
						onset_hb_q    <= {b_oh, onset_hb_q[TW-1:1]};
						worker_base_q <= {b_wb, worker_base_q[WW-1:1]};
						next_rep_q    <= {b_rep, next_rep_q[TW-1:1]};
					end
					if (pass_last) begin
						state_q <= ST_FIN;
						if (!enable_q) begin
							stalled_q <= 1'b0;
						end else if (stale) begin
							if (!stalled_q) begin
								stalled_q     <= 1'b1;
								onset_hb_q    <= hb_sr_q;
								worker_base_q <= wk_sr_q;
								next_rep_q    <= nrt_new_q;
								if (stall_cnt_q != '1) begin
									stall_cnt_q <= stall_cnt_q + 1'b1;
								end
							end else if (wrk_armed_q && !rep_gt_now_q) begin
								next_rep_q <= nrt_new_q;
							end
						end else if (stalled_q) begin
							stalled_q <= 1'b0;
							state_q   <= ST_DIV;
							div_go_q  <= 1'b1;
						end
					end
				end
				ST_DIV: begin
					if (div_status.done) begin
						state_q <= ST_FIN;
						if (div_quo > worst_q) begin
							worst_q <= div_quo;
						end
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Serial datapath and pending result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && take) begin
			now_sr_q     <= sample.now_tick;
			hb_sr_q      <= sample.heartbeat_tick;
			wk_sr_q      <= sample.worker_count;
			thr_sr_q     <= thresh_q;
			freq_eff_q   <= (freq_q == '0) ? hsm_pkg::FREQ_DEFAULT : freq_q;
			f2_sr_q      <= {(TW-1)'((freq_q == '0) ? hsm_pkg::FREQ_DEFAULT : freq_q), 1'b0};
			bw_age_q     <= 1'b0;
			bw_dur_q     <= 1'b0;
			bw_adv_q     <= 1'b0;
			cy_rep_q     <= 1'b0;
			now_gt_hb_q  <= 1'b0;
			age_gt_thr_q <= 1'b0;
			rep_gt_now_q <= 1'b0;
			hist_q       <= '0;
			mcy_q        <= '0;
		end else if (state_q == ST_PASS) begin
			if (pass_act) begin
				now_sr_q  <= {b_now, now_sr_q[TW-1:1]};
				hb_sr_q   <= {b_hb, hb_sr_q[TW-1:1]};
				wk_sr_q   <= {b_wk, wk_sr_q[WW-1:1]};
				thr_sr_q  <= {b_thr, thr_sr_q[TW-1:1]};
				f2_sr_q   <= {b_f2, f2_sr_q[TW-1:1]};
				nrt_new_q <= {b_now ^ b_f2 ^ cy_rep_q, nrt_new_q[TW-1:1]};
				adv_q     <= {b_wk ^ b_wb ^ bw_adv_q, adv_q[WW-1:1]};
				bw_age_q  <= (!b_now & b_hb) | (!(b_now ^ b_hb) & bw_age_q);
				bw_dur_q  <= (!b_now & b_oh) | (!(b_now ^ b_oh) & bw_dur_q);
				bw_adv_q  <= (!b_wk & b_wb) | (!(b_wk ^ b_wb) & bw_adv_q);
				cy_rep_q  <= (b_now & b_f2) | ((b_now ^ b_f2) & cy_rep_q);
				// LSB-first magnitude compares: a higher differing bit overrides.
				now_gt_hb_q  <= (b_now & !b_hb) | (!(b_now ^ b_hb) & now_gt_hb_q);
				age_gt_thr_q <= (b_age & !b_thr) | (!(b_age ^ b_thr) & age_gt_thr_q);
				rep_gt_now_q <= (b_rep & !b_now) | (!(b_rep ^ b_now) & rep_gt_now_q);
			end
			hist_q <= {hist_q[hsm_pkg::MUL_W-3:0], b_diff};
			mcy_q  <= msum[3:1];
			prod_q <= {msum[0], prod_q[hsm_pkg::DVD_W-1:1]};
			if (pass_last) begin
				res_kind_q <= hsm_pkg::EV_NONE;
				res_dur_q  <= '0;
				res_adv_q  <= '0;
				res_wv_q   <= 1'b0;
				res_pet_q  <= enable_q & pet_armed_q;
				if (enable_q) begin
					if (stale) begin
						if (!stalled_q) begin
							res_kind_q <= hsm_pkg::EV_ONSET;
						end else begin
							res_kind_q <= hsm_pkg::EV_MID;
							if (wrk_armed_q && !rep_gt_now_q) begin
								res_adv_q <= adv_q;
								res_wv_q  <= 1'b1;
							end
						end
					end else if (stalled_q) begin
						res_kind_q <= hsm_pkg::EV_RECOVER;
						if (wrk_armed_q) begin
							res_adv_q <= adv_q;
							res_wv_q  <= 1'b1;
						end
					end
				end
			end
		end else if (state_q == ST_DIV && div_status.done) begin
			res_dur_q <= div_quo;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			result_q.event_kind        <= res_kind_q;
			result_q.stall_total       <= stall_cnt_q;
			result_q.duration_ms       <= res_dur_q;
			result_q.worst_duration_ms <= worst_q;
			result_q.worker_advance    <= res_adv_q;
			result_q.worker_valid      <= res_wv_q;
			result_q.led_on            <= stalled_q;
			result_q.pet_strobe        <= res_pet_q;
		end
	end

	hsm_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (prod_q),
		.divisor  (freq_eff_q),
		.status   (div_status),
		.quotient (div_quo)
	);

	assign sample_stall = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The divider only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_status.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	// A worker report only accompanies a mid-stall sample or a recovery.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.worker_valid |->
			(result.event_kind == hsm_pkg::EV_MID || result.event_kind == hsm_pkg::EV_RECOVER))
		else $error("worker report on a sample that is neither mid-stall nor recovery");

	// A nonzero duration only appears on a recovery.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.duration_ms != '0 |-> result.event_kind == hsm_pkg::EV_RECOVER)
		else $error("duration reported outside a recovery");

	// The worst duration always covers the duration just reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.worst_duration_ms >= result.duration_ms)
		else $error("worst duration below reported duration");

endmodule

`default_nettype wire
